FILE: hw/rtl/csh_pkg.sv
package csh_pkg;

    localparam int CNT_W  = 64;
    localparam int TOT_W  = 68;
    localparam int WIN_W  = 10;
    localparam int STI_W  = 4;
    localparam int SLOT_W = 3;
    localparam int Q_BITS = 23;
    localparam int DIV_CW = 5;
    localparam int P100_W = CNT_W + 7;

    localparam logic [WIN_W-1:0]  WIN_SHORT_RST = 10'd60;
    localparam logic [WIN_W-1:0]  WIN_MID_RST   = 10'd300;
    localparam logic [WIN_W-1:0]  WIN_LONG_RST  = 10'd900;
    localparam logic [Q_BITS-1:0] PCT_MAX       = 23'd6553600;

    typedef enum logic [1:0] {
        MD_SAMPLE,
        MD_FAIL,
        MD_QUERY,
        MD_NONE
    } t_mode;

    typedef enum logic [1:0] {
        QS_OK,
        QS_BAD,
        QS_NOT_STARTED,
        QS_FAILED
    } t_qsts;

    typedef enum logic [1:0] {
        CFG_STARTED,
        CFG_WIN_SHORT,
        CFG_WIN_MID,
        CFG_WIN_LONG
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PEND_WR,
        ST_CP_RD,
        ST_CP_WR,
        ST_COMMIT,
        ST_Q_CURR,
        ST_Q_CHK,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_SUM_C,
        ST_SUM_B,
        ST_SUM_ACC,
        ST_SCALE,
        ST_DIV,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic  cap;
        logic  pend_wr;
        logic  cp_rd;
        logic  cp_wr;
        logic  commit;
        logic  q_curr;
        logic  walk_rd;
        logic  walk_inc;
        logic  sum_c;
        logic  sum_b;
        logic  sum_acc;
        logic  scale;
        logic  div_step;
        logic  out_load;
        t_qsts out_status;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  slot_ok;
        logic  st_ok;
        logic  win_ok;
        logic  started;
        logic  fill_zero;
        logic  fill_one;
        logic  last;
        logic  vld;
        logic  idx_last;
        logic  div_last;
        logic  total_zero;
        logic  out_busy;
    } t_sts;

endpackage

FILE: hw/rtl/cpu_state_share_history_core.sv
// a sample element is captured and written to the pending store; the last one
// adds a copy sweep of all states into the ring and a commit; a query walks
// past invalid slots, sums over all states and ends in a restoring divider
// throughput: one item at a time, the divider and one memory read port set the pace
// reset: synchronous active-low, clears ring pointers, fill counts and the started flag, restores window defaults;
// ring memories are not cleared and only filled entries are ever read
module cpu_state_share_history_core
    import csh_pkg::*;
#(
    parameter int HISTORY_DEPTH = 1024,
    parameter int STATE_COUNT   = 10,
    parameter int CPU_COUNT     = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_mode,
    input  logic [SLOT_W-1:0]   i_cpu_slot,
    input  logic [STI_W-1:0]    i_state_index,
    input  logic [CNT_W-1:0]    i_counter_value,
    input  logic                i_last_element,
    input  logic [1:0]          i_window_select,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic [Q_BITS-1:0]   o_percent_q16,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [WIN_W-1:0]    i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    csh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    csh_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .STATE_COUNT   (STATE_COUNT),
        .CPU_COUNT     (CPU_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mode          (i_mode),
        .i_cpu_slot      (i_cpu_slot),
        .i_state_index   (i_state_index),
        .i_counter_value (i_counter_value),
        .i_last_element  (i_last_element),
        .i_window_select (i_window_select),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_percent_q16   (o_percent_q16),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts)
    );

endmodule

FILE: hw/rtl/csh_ctrl.sv
module csh_ctrl
    import csh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    t_qsts  r_qsts, n_qsts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_qsts  <= QS_OK;
        end else begin
            r_state <= n_state;
            r_qsts  <= n_qsts;
        end
    end

    always_comb begin
        n_state = r_state;
        n_qsts  = r_qsts;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                n_qsts = QS_OK;
                unique case (i_sts.mode)
                    MD_SAMPLE: n_state = i_sts.slot_ok ? ST_PEND_WR : ST_IDLE;
                    MD_FAIL:   n_state = i_sts.slot_ok ? ST_COMMIT : ST_IDLE;
                    MD_QUERY: begin
                        if (!i_sts.st_ok || !i_sts.win_ok) begin
                            n_qsts  = QS_BAD;
                            n_state = ST_RESULT;
                        end else if (!i_sts.started) begin
                            n_qsts  = QS_NOT_STARTED;
                            n_state = ST_RESULT;
                        end else if (!i_sts.slot_ok) begin
                            n_qsts  = QS_FAILED;
                            n_state = ST_RESULT;
                        end else if (i_sts.fill_zero) begin
                            n_state = ST_RESULT;
                        end else begin
                            n_state = ST_Q_CURR;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_PEND_WR: n_state = i_sts.last ? ST_CP_RD : ST_IDLE;
            ST_CP_RD:   n_state = ST_CP_WR;
            ST_CP_WR:   n_state = i_sts.idx_last ? ST_COMMIT : ST_CP_RD;
            ST_COMMIT:  n_state = ST_IDLE;
            ST_Q_CURR:  n_state = ST_Q_CHK;
            ST_Q_CHK: begin
                if (!i_sts.vld) begin
                    n_qsts  = QS_FAILED;
                    n_state = ST_RESULT;
                end else if (i_sts.fill_one) begin
                    n_state = ST_SUM_C;
                end else begin
                    n_state = ST_WALK_RD;
                end
            end
            ST_WALK_RD:  n_state = ST_WALK_CHK;
            ST_WALK_CHK: n_state = i_sts.vld ? ST_SUM_C : ST_WALK_RD;
            ST_SUM_C:    n_state = ST_SUM_B;
            ST_SUM_B:    n_state = ST_SUM_ACC;
            ST_SUM_ACC:  n_state = i_sts.idx_last ? ST_SCALE : ST_SUM_C;
            ST_SCALE:    n_state = i_sts.total_zero ? ST_RESULT : ST_DIV;
            ST_DIV:      n_state = i_sts.div_last ? ST_RESULT : ST_DIV;
            ST_RESULT:   n_state = i_sts.out_busy ? ST_RESULT : ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.out_status = r_qsts;
        o_in_stall       = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE:     o_cmd.cap      = i_in_valid;
            ST_PEND_WR:  o_cmd.pend_wr  = 1'b1;
            ST_CP_RD:    o_cmd.cp_rd    = 1'b1;
            ST_CP_WR:    o_cmd.cp_wr    = 1'b1;
            ST_COMMIT:   o_cmd.commit   = 1'b1;
            ST_Q_CURR:   o_cmd.q_curr   = 1'b1;
            ST_WALK_RD:  o_cmd.walk_rd  = 1'b1;
            ST_WALK_CHK: o_cmd.walk_inc = !i_sts.vld;
            ST_SUM_C:    o_cmd.sum_c    = 1'b1;
            ST_SUM_B:    o_cmd.sum_b    = 1'b1;
            ST_SUM_ACC:  o_cmd.sum_acc  = 1'b1;
            ST_SCALE:    o_cmd.scale    = !i_sts.total_zero;
            ST_DIV:      o_cmd.div_step = 1'b1;
            ST_RESULT:   o_cmd.out_load = !i_sts.out_busy;
            default:     o_cmd.cap      = 1'b0;
        endcase
    end

`ifndef SYNTHESIS
    a_copy_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CP_WR && i_sts.idx_last) |=> (r_state == ST_COMMIT))
        else $error("copy sweep did not end in commit");

    a_result_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && !i_sts.out_busy) |=> (r_state == ST_IDLE))
        else $error("result not handed over");

    a_zero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCALE && i_sts.total_zero) |=> (r_state == ST_RESULT && r_qsts == QS_OK))
        else $error("zero total must skip division");
`endif

endmodule

FILE: hw/rtl/csh_dp.sv
module csh_dp
    import csh_pkg::*;
#(
    parameter int HISTORY_DEPTH = 1024,
    parameter int STATE_COUNT   = 10,
    parameter int CPU_COUNT     = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_mode,
    input  logic [SLOT_W-1:0]   i_cpu_slot,
    input  logic [STI_W-1:0]    i_state_index,
    input  logic [CNT_W-1:0]    i_counter_value,
    input  logic                i_last_element,
    input  logic [1:0]          i_window_select,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic [Q_BITS-1:0]   o_percent_q16,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [WIN_W-1:0]    i_cfg_data,
    input  t_cmd                i_cmd,
    output t_sts                o_sts
);

    localparam int SLOT_COUNT = CPU_COUNT + 1;
    localparam int SLOTW = $clog2(SLOT_COUNT);
    localparam int IW    = $clog2(HISTORY_DEPTH);
    localparam int FW    = $clog2(HISTORY_DEPTH + 1);
    localparam int XW    = IW + 2;
    localparam int BW    = (FW > WIN_W) ? FW : WIN_W;
    localparam int SCW   = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
    localparam int HDEP  = SLOT_COUNT * HISTORY_DEPTH * STATE_COUNT;
    localparam int HAW   = $clog2(HDEP);
    localparam int VDEP  = SLOT_COUNT * HISTORY_DEPTH;
    localparam int VAW   = $clog2(VDEP);
    localparam int PDEP  = SLOT_COUNT * STATE_COUNT;
    localparam int PAW   = $clog2(PDEP);

    logic [CNT_W-1:0] r_hist [HDEP];
    logic             r_vmem [VDEP];
    logic [CNT_W-1:0] r_pend [PDEP];
    logic [PDEP-1:0]  r_pvalid;

    logic [IW-1:0]    r_oldest [SLOT_COUNT];
    logic [FW-1:0]    r_fill   [SLOT_COUNT];

    logic             r_started;
    logic [WIN_W-1:0] r_win_s, r_win_m, r_win_l;

    t_mode            r_mode;
    logic [SLOT_W-1:0] r_slot;
    logic [STI_W-1:0] r_st;
    logic [CNT_W-1:0] r_val;
    logic             r_last;
    logic [1:0]       r_wsel;

    logic [SCW-1:0]   r_idx;
    logic [IW-1:0]    r_curr, r_base;
    logic             r_raw;
    logic             r_vld_rd;
    logic [CNT_W-1:0] r_hrd, r_prd, r_c;
    logic             r_pv_rd;
    logic [TOT_W-1:0] r_total;
    logic [CNT_W-1:0] r_part;
    logic [TOT_W:0]   r_rem;
    logic [Q_BITS-1:0] r_sh, r_quot;
    logic [DIV_CW-1:0] r_div_cnt;

    logic             r_out_valid;
    t_qsts            r_out_status;
    logic [Q_BITS-1:0] r_out_pct;

    logic [SLOTW-1:0] w_sidx;
    logic [IW-1:0]    w_oldest, w_curr, w_tail, w_back, w_base, w_base_inc;
    logic [FW-1:0]    w_fill;
    logic [XW-1:0]    w_sum_c, w_sum_t, w_base_x;
    logic [FW-1:0]    w_fm1;
    logic [WIN_W-1:0] w_win;
    logic [PAW-1:0]   w_pa_wr, w_pa_rd;
    logic [HAW-1:0]   w_ha_rd, w_ha_wr;
    logic [VAW-1:0]   w_va_rd, w_va_wr;
    logic [CNT_W-1:0] w_p, w_d;
    logic [P100_W-1:0] w_p100;
    logic [TOT_W:0]   w_t, w_dv;
    logic             w_ge;

    function automatic logic [HAW-1:0] f_haddr(input logic [SLOTW-1:0] s,
                                               input logic [IW-1:0] r,
                                               input logic [SCW-1:0] i);
        return HAW'((HAW'(s) * HAW'(HISTORY_DEPTH) + HAW'(r)) * HAW'(STATE_COUNT) + HAW'(i));
    endfunction

    function automatic logic [VAW-1:0] f_vaddr(input logic [SLOTW-1:0] s,
                                               input logic [IW-1:0] r);
        return VAW'(VAW'(s) * VAW'(HISTORY_DEPTH) + VAW'(r));
    endfunction

    assign w_sidx   = SLOTW'(r_slot);
    assign w_oldest = r_oldest[w_sidx];
    assign w_fill   = r_fill[w_sidx];

    // ring positions of newest sample and next free entry
    always_comb begin
        w_sum_c = XW'(w_oldest) + XW'(w_fill) - XW'(1);
        if (w_sum_c >= XW'(HISTORY_DEPTH)) w_sum_c = w_sum_c - XW'(HISTORY_DEPTH);
        w_curr  = w_sum_c[IW-1:0];
        w_sum_t = XW'(w_oldest) + XW'(w_fill);
        if (w_sum_t >= XW'(HISTORY_DEPTH)) w_sum_t = w_sum_t - XW'(HISTORY_DEPTH);
        w_tail  = w_sum_t[IW-1:0];
    end

    always_comb begin
        case (r_wsel)
            2'd1:    w_win = r_win_m;
            2'd2:    w_win = r_win_l;
            default: w_win = r_win_s;
        endcase
        w_fm1  = w_fill - FW'(1);
        w_back = (BW'(w_fm1) < BW'(w_win)) ? IW'(w_fm1) : IW'(w_win);
        if (w_curr >= w_back) begin
            w_base_x = XW'(w_curr) - XW'(w_back);
        end else begin
            w_base_x = XW'(w_curr) + XW'(HISTORY_DEPTH) - XW'(w_back);
        end
        w_base = w_base_x[IW-1:0];
        w_base_inc = (r_base == IW'(HISTORY_DEPTH - 1)) ? '0 : r_base + IW'(1);
    end

    assign w_pa_wr = PAW'(PAW'(w_sidx) * PAW'(STATE_COUNT) + PAW'(r_st));
    assign w_pa_rd = PAW'(PAW'(w_sidx) * PAW'(STATE_COUNT) + PAW'(r_idx));
    assign w_ha_wr = f_haddr(w_sidx, w_tail, r_idx);
    assign w_ha_rd = f_haddr(w_sidx, i_cmd.sum_b ? r_base : r_curr, r_idx);
    assign w_va_wr = f_vaddr(w_sidx, w_tail);
    assign w_va_rd = f_vaddr(w_sidx, i_cmd.q_curr ? w_curr : r_base);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cp_wr) r_hist[w_ha_wr] <= r_pv_rd ? r_prd : '0;
        if (i_cmd.sum_c || i_cmd.sum_b) r_hrd <= r_hist[w_ha_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_vmem[w_va_wr] <= (r_mode == MD_SAMPLE);
        if (i_cmd.q_curr || i_cmd.walk_rd) r_vld_rd <= r_vmem[w_va_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pend_wr && o_sts.st_ok) r_pend[w_pa_wr] <= r_val;
        if (i_cmd.cp_rd) begin
            r_prd   <= r_pend[w_pa_rd];
            r_pv_rd <= r_pvalid[w_pa_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= '0;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                r_oldest[s] <= '0;
                r_fill[s]   <= '0;
            end
        end else begin
            if (i_cmd.pend_wr && o_sts.st_ok) r_pvalid[w_pa_wr] <= 1'b1;
            if (i_cmd.commit) begin
                if (w_fill < FW'(HISTORY_DEPTH)) begin
                    r_fill[w_sidx] <= w_fill + FW'(1);
                end else begin
                    r_oldest[w_sidx] <= (w_oldest == IW'(HISTORY_DEPTH - 1)) ?
                                        '0 : w_oldest + IW'(1);
                end
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_win_s   <= WIN_SHORT_RST;
            r_win_m   <= WIN_MID_RST;
            r_win_l   <= WIN_LONG_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_STARTED:   r_started <= i_cfg_data[0];
                CFG_WIN_SHORT: r_win_s   <= i_cfg_data;
                CFG_WIN_MID:   r_win_m   <= i_cfg_data;
                CFG_WIN_LONG:  r_win_l   <= i_cfg_data;
                default:       r_started <= r_started;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_mode <= t_mode'(i_mode);
            r_slot <= i_cpu_slot;
            r_st   <= i_state_index;
            r_val  <= i_counter_value;
            r_last <= i_last_element;
            r_wsel <= i_window_select;
        end
    end

    assign w_p = r_raw ? '0 : r_hrd;
    assign w_d = (r_c > w_p) ? r_c - w_p : '0;

    // part * 100, then shifted by 16 into the dividend
    assign w_p100 = (P100_W'(r_part) << 6) + (P100_W'(r_part) << 5) + (P100_W'(r_part) << 2);
    assign w_dv   = {1'b0, r_total};
    assign w_t    = {r_rem[TOT_W-1:0], r_sh[Q_BITS-1]};
    assign w_ge   = (w_t >= w_dv);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_idx   <= '0;
            r_total <= '0;
            r_part  <= '0;
            r_quot  <= '0;
        end
        if (i_cmd.cp_wr || i_cmd.sum_acc) r_idx <= r_idx + SCW'(1);
        if (i_cmd.q_curr) begin
            r_curr <= w_curr;
            r_base <= w_base;
            r_raw  <= (w_fill == FW'(1));
        end
        if (i_cmd.walk_inc) r_base <= w_base_inc;
        if (i_cmd.sum_b) r_c <= r_hrd;
        if (i_cmd.sum_acc) begin
            r_total <= r_total + TOT_W'(w_d);
            if (STI_W'(r_idx) == r_st) r_part <= w_d;
        end
        if (i_cmd.scale) begin
            r_rem     <= (TOT_W + 1)'(w_p100[P100_W-1:7]);
            r_sh      <= {w_p100[6:0], 16'd0};
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= w_ge ? w_t - w_dv : w_t;
            r_sh      <= r_sh << 1;
            r_quot    <= {r_quot[Q_BITS-2:0], w_ge};
            r_div_cnt <= r_div_cnt + DIV_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_pct    <= (i_cmd.out_status == QS_OK) ? r_quot : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_percent_q16 = r_out_pct;

    always_comb begin
        o_sts.mode       = r_mode;
        o_sts.slot_ok    = (32'(r_slot) <= CPU_COUNT);
        o_sts.st_ok      = (32'(r_st) < STATE_COUNT);
        o_sts.win_ok     = (r_wsel != 2'd3);
        o_sts.started    = r_started;
        o_sts.fill_zero  = (w_fill == '0);
        o_sts.fill_one   = r_raw;
        o_sts.last       = r_last;
        o_sts.vld        = r_vld_rd;
        o_sts.idx_last   = (r_idx == SCW'(STATE_COUNT - 1));
        o_sts.div_last   = (r_div_cnt == DIV_CW'(Q_BITS - 1));
        o_sts.total_zero = (r_total == '0);
        o_sts.out_busy   = r_out_valid && i_out_stall;
    end

`ifndef SYNTHESIS
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == QS_OK) |-> (r_out_pct <= PCT_MAX))
        else $error("share above one hundred percent");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_fill[w_sidx] <= FW'(HISTORY_DEPTH)))
        else $error("fill count beyond ring depth");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != QS_OK) |-> (r_out_pct == '0))
        else $error("nonzero share on error status");
`endif

endmodule
